// ----- rtl/sscf_pkg.sv -----
// Package for the sphere contact force pipeline: payload types, stage types and step functions.
`default_nettype none
package sscf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIAM_W    = 31;
  localparam int COEF_W    = 24;
  localparam int FORCE_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = COORD_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REPULSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH      = 2'd2;

  localparam logic [COEF_W-1:0] REPULSION_RST  = 24'd131072;
  localparam logic [COEF_W-1:0] ATTRACTION_RST = 24'd65536;
  localparam logic [COEF_W-1:0] REACH_RST      = 24'd655360;

  localparam int SQ1_STEPS  = 34;
  localparam int SQ2_STEPS  = 35;
  localparam int DIV2_STEPS = 40;

  localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic [DIAM_W-1:0]         diameter_a;
    logic [DIAM_W-1:0]         diameter_b;
    logic [COEF_W-1:0]         coefficient_a;
    logic [COEF_W-1:0]         coefficient_b;
  } in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      coincident;
    logic                      saturated;
  } out_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } vec_t;

  typedef struct packed {
    vec_t              v;
    logic [COEF_W-1:0] minc;
    logic [DIAM_W-1:0] da;
    logic [DIAM_W-1:0] db;
  } a1_t;

  typedef struct packed {
    vec_t              v;
    logic [2:0][65:0]  sqm;
    logic [47:0]       extp;
    logic [DIAM_W-1:0] da;
    logic [DIAM_W-1:0] db;
  } a2_t;

  typedef struct packed {
    vec_t        v;
    logic [67:0] sum4;
    logic [33:0] r1;
    logic [33:0] r2;
  } a3_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [33:0] root;
    logic [67:0] rad;
  } sq1_t;

  typedef struct packed {
    logic [36:0] rem;
    logic [34:0] root;
    logic [69:0] rad;
  } sq2_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [33:0] quo;
    logic [33:0] num;
  } div1_t;

  typedef struct packed {
    logic [49:0] rem;
    logic [39:0] quo;
    logic [39:0] num;
  } div2_t;

  typedef struct packed {
    vec_t        v;
    sq1_t        s;
    div1_t       d;
    logic [34:0] sumr;
  } b_t;

  typedef struct packed {
    vec_t        v;
    logic [33:0] rr;
    logic [33:0] cdist;
    logic [34:0] delta;
    logic        nohit;
    logic        coin;
  } c_t;

  typedef struct packed {
    vec_t        v;
    sq2_t        s;
    logic [58:0] kd;
    logic [33:0] cdist;
    logic        nohit;
    logic        coin;
  } d_t;

  typedef struct packed {
    vec_t        v;
    logic [58:0] gs;
    logic [58:0] kd;
    logic [33:0] cdist;
    logic        nohit;
    logic        coin;
  } e0_t;

  typedef struct packed {
    vec_t        v;
    logic [58:0] fmag;
    logic        fneg;
    logic [33:0] cdist;
    logic        nohit;
    logic        coin;
  } e1_t;

  typedef struct packed {
    logic [2:0][62:0] pl;
    logic [2:0][61:0] ph;
    logic [2:0]       sign;
    logic [33:0]      cdist;
    logic             nohit;
    logic             coin;
  } e2_t;

  typedef struct packed {
    logic [2:0][91:0] num;
    logic [2:0]       sign;
    logic [33:0]      cdist;
    logic             nohit;
    logic             coin;
  } e3_t;

  typedef struct packed {
    div2_t [2:0] dv;
    logic [2:0]  ovf;
    logic [2:0]  sign;
    logic [49:0] den;
    logic        nohit;
    logic        coin;
  } f_t;

  // One bit of a digit-by-digit square root; two radicand bits enter per step.
  function automatic sq1_t sq1_step(sq1_t s);
    logic [35:0] r;
    logic [35:0] t;
    sq1_t        o;
    r = {s.rem[33:0], s.rad[67:66]};
    t = {s.root, 2'b01};
    o.rad = {s.rad[65:0], 2'b00};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[32:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[32:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq2_t sq2_step(sq2_t s);
    logic [36:0] r;
    logic [36:0] t;
    sq2_t        o;
    r = {s.rem[34:0], s.rad[69:68]};
    t = {s.root, 2'b01};
    o.rad = {s.rad[67:0], 2'b00};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[33:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[33:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of a restoring division whose quotient is known to fit.
  function automatic div1_t div1_step(div1_t s, logic [34:0] den);
    logic [35:0] r;
    logic [35:0] dif;
    div1_t       o;
    r   = {s.rem, s.num[33]};
    dif = r - {1'b0, den};
    o.num = {s.num[32:0], 1'b0};
    if (r >= {1'b0, den}) begin
      o.rem = dif[34:0];
      o.quo = {s.quo[32:0], 1'b1};
    end else begin
      o.rem = r[34:0];
      o.quo = {s.quo[32:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div2_t div2_step(div2_t s, logic [49:0] den);
    logic [50:0] r;
    logic [50:0] dif;
    div2_t       o;
    r   = {s.rem, s.num[39]};
    dif = r - {1'b0, den};
    o.num = {s.num[38:0], 1'b0};
    if (r >= {1'b0, den}) begin
      o.rem = dif[49:0];
      o.quo = {s.quo[38:0], 1'b1};
    end else begin
      o.rem = r[49:0];
      o.quo = {s.quo[38:0], 1'b0};
    end
    return o;
  endfunction

  function automatic b_t b_step(b_t b);
    b_t o;
    o      = b;
    o.s    = sq1_step(b.s);
    o.d    = div1_step(b.d, b.sumr);
    return o;
  endfunction

  function automatic d_t d_step(d_t d);
    d_t o;
    o   = d;
    o.s = sq2_step(d.s);
    return o;
  endfunction

  function automatic f_t f_step(f_t f);
    f_t o;
    o = f;
    for (int i = 0; i < 3; i++) begin
      o.dv[i] = div2_step(f.dv[i], f.den);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sphere_sphere_contact_force.sv -----
// Soft-sphere contact force, deep pipeline, one sphere pair per cycle unless stalled.
//
// Input beats (in_valid/in_stall) carry two centers, two diameters and two
// interaction coefficients. Result beats (out_valid/out_stall) carry the force
// on the first sphere as three saturated Q24.16 components, plus coincident
// and saturated flags. The cfg channel (cfg_valid/cfg_ready, always ready)
// writes the repulsion, attraction and reach gain registers by index; write
// them only while no pair is in flight.
// Throughput is one pair per cycle while no result beat is stalled. The
// accepting edge loads the first of 121 register stages: three setup stages,
// a load stage and 34 steps of the distance square root running alongside the
// reduced-radius divider, a compare stage, a load stage and 35 steps of the
// second square root, four multiply and add stages, a load stage and 40 steps of
// the final per-axis dividers, and the output register. The bit-serial
// stages set the depth.
// When out_valid is high and out_stall is asserted, the whole pipeline holds
// and in_stall is raised in the same cycle; no beat is dropped or repeated.
// Reset clears all valid bits and loads the default coefficients
// (repulsion 2.0, attraction 1.0, reach gain 10.0).
`default_nettype none
module sphere_sphere_contact_force (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  sscf_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output sscf_pkg::out_t                 out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [sscf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sscf_pkg::COEF_W-1:0]     cfg_data
);
  import sscf_pkg::*;

  localparam int NSTG = 3 + (SQ1_STEPS + 1) + 1 + (SQ2_STEPS + 1) + 4 + (DIV2_STEPS + 1);

  logic [COEF_W-1:0] k_r;
  logic [COEF_W-1:0] gamma_r;
  logic [COEF_W-1:0] reach_r;

  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  out_t            out_data_r;
  logic            adv;

  a1_t a1_r;
  a2_t a2_r;
  a3_t a3_r;
  b_t  b_r [0:SQ1_STEPS];
  c_t  c_r;
  d_t  d_r [0:SQ2_STEPS];
  e0_t e0_r;
  e1_t e1_r;
  e2_t e2_r;
  e3_t e3_r;
  f_t  f_r [0:DIV2_STEPS];

  logic signed [COORD_W-1:0] ca [3];
  logic signed [COORD_W-1:0] cb [3];
  a1_t  a1_nxt;
  b_t   b0_nxt;
  c_t   c_nxt;
  d_t   d0_nxt;
  e1_t  e1_nxt;
  f_t   f0_nxt;
  out_t out_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= REPULSION_RST;
      gamma_r <= ATTRACTION_RST;
      reach_r <= REACH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REPULSION:  k_r     <= cfg_data;
        CFG_ATTRACTION: gamma_r <= cfg_data;
        CFG_REACH:      reach_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Center differences as sign and magnitude.
  always_comb begin
    logic signed [MAG_W-1:0] dif;
    ca[0] = in_data.center_a_x;
    ca[1] = in_data.center_a_y;
    ca[2] = in_data.center_a_z;
    cb[0] = in_data.center_b_x;
    cb[1] = in_data.center_b_y;
    cb[2] = in_data.center_b_z;
    a1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      dif = {ca[i][COORD_W-1], ca[i]} - {cb[i][COORD_W-1], cb[i]};
      a1_nxt.v.neg[i] = dif[MAG_W-1];
      a1_nxt.v.mag[i] = dif[MAG_W-1] ? unsigned'(-dif) : unsigned'(dif);
    end
    a1_nxt.minc = (in_data.coefficient_a < in_data.coefficient_b) ?
                  in_data.coefficient_a : in_data.coefficient_b;
    a1_nxt.da = in_data.diameter_a;
    a1_nxt.db = in_data.diameter_b;
  end

  always_comb begin
    logic [67:0] prod;
    prod              = 68'(a3_r.r1) * 68'(a3_r.r2);
    b0_nxt.v          = a3_r.v;
    b0_nxt.s.rem      = '0;
    b0_nxt.s.root     = '0;
    b0_nxt.s.rad      = a3_r.sum4;
    b0_nxt.sumr       = 35'(a3_r.r1) + 35'(a3_r.r2);
    b0_nxt.d.rem      = {1'b0, prod[67:34]};
    b0_nxt.d.num      = prod[33:0];
    b0_nxt.d.quo      = '0;
  end

  always_comb begin
    c_nxt.v     = b_r[SQ1_STEPS].v;
    c_nxt.cdist = b_r[SQ1_STEPS].s.root;
    c_nxt.rr    = b_r[SQ1_STEPS].d.quo;
    c_nxt.nohit = b_r[SQ1_STEPS].sumr < {1'b0, b_r[SQ1_STEPS].s.root};
    c_nxt.coin  = (b_r[SQ1_STEPS].s.root == '0);
    c_nxt.delta = b_r[SQ1_STEPS].sumr - {1'b0, b_r[SQ1_STEPS].s.root};
  end

  always_comb begin
    d0_nxt.v      = c_r.v;
    d0_nxt.s.rem  = '0;
    d0_nxt.s.root = '0;
    d0_nxt.s.rad  = 70'(c_r.rr) * 70'(c_r.delta);
    d0_nxt.kd     = 59'(k_r) * 59'(c_r.delta);
    d0_nxt.cdist  = c_r.cdist;
    d0_nxt.nohit  = c_r.nohit;
    d0_nxt.coin   = c_r.coin;
  end

  always_comb begin
    e1_nxt.v     = e0_r.v;
    e1_nxt.fneg  = e0_r.kd < e0_r.gs;
    e1_nxt.fmag  = e1_nxt.fneg ? (e0_r.gs - e0_r.kd) : (e0_r.kd - e0_r.gs);
    e1_nxt.cdist = e0_r.cdist;
    e1_nxt.nohit = e0_r.nohit;
    e1_nxt.coin  = e0_r.coin;
  end

  // Dividing by the distance shifted up by 16 gives the shifted quotient
  // directly; a quotient of 2^40 or more is caught up front and only saturates.
  always_comb begin
    f0_nxt.den   = {e3_r.cdist, 16'b0};
    f0_nxt.sign  = e3_r.sign;
    f0_nxt.nohit = e3_r.nohit;
    f0_nxt.coin  = e3_r.coin;
    for (int i = 0; i < 3; i++) begin
      f0_nxt.ovf[i]    = e3_r.num[i][91:56] >= {2'b0, e3_r.cdist};
      f0_nxt.dv[i].rem = e3_r.num[i][89:40];
      f0_nxt.dv[i].num = e3_r.num[i][39:0];
      f0_nxt.dv[i].quo = '0;
    end
  end

  always_comb begin
    logic [FORCE_W-1:0] q;
    logic [FORCE_W-1:0] val [3];
    logic [2:0]         sat;
    for (int i = 0; i < 3; i++) begin
      q = f_r[DIV2_STEPS].dv[i].quo;
      if (f_r[DIV2_STEPS].sign[i]) begin
        sat[i] = f_r[DIV2_STEPS].ovf[i] || (q[FORCE_W-1] && (q[FORCE_W-2:0] != '0));
        val[i] = sat[i] ? FORCE_MIN : (~q + 1'b1);
      end else begin
        sat[i] = f_r[DIV2_STEPS].ovf[i] || q[FORCE_W-1];
        val[i] = sat[i] ? FORCE_MAX : q;
      end
    end
    if (f_r[DIV2_STEPS].nohit || f_r[DIV2_STEPS].coin) begin
      out_nxt            = '0;
      out_nxt.coincident = !f_r[DIV2_STEPS].nohit;
    end else begin
      out_nxt.force_x    = val[0];
      out_nxt.force_y    = val[1];
      out_nxt.force_z    = val[2];
      out_nxt.coincident = 1'b0;
      out_nxt.saturated  = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= a1_nxt;

      a2_r.v    <= a1_r.v;
      a2_r.da   <= a1_r.da;
      a2_r.db   <= a1_r.db;
      a2_r.extp <= 48'(reach_r) * 48'(a1_r.minc);
      for (int i = 0; i < 3; i++) begin
        a2_r.sqm[i] <= 66'(a1_r.v.mag[i]) * 66'(a1_r.v.mag[i]);
      end

      a3_r.v    <= a2_r.v;
      a3_r.sum4 <= {a2_r.sqm[0] + a2_r.sqm[1] + a2_r.sqm[2], 2'b00};
      a3_r.r1   <= 34'(a2_r.da) + 34'(a2_r.extp[47:FRAC_BITS-1]);
      a3_r.r2   <= 34'(a2_r.db) + 34'(a2_r.extp[47:FRAC_BITS-1]);

      b_r[0] <= b0_nxt;
      for (int k = 1; k <= SQ1_STEPS; k++) begin
        b_r[k] <= b_step(b_r[k-1]);
      end

      c_r <= c_nxt;

      d_r[0] <= d0_nxt;
      for (int k = 1; k <= SQ2_STEPS; k++) begin
        d_r[k] <= d_step(d_r[k-1]);
      end

      e0_r.v     <= d_r[SQ2_STEPS].v;
      e0_r.gs    <= 59'(gamma_r) * 59'(d_r[SQ2_STEPS].s.root);
      e0_r.kd    <= d_r[SQ2_STEPS].kd;
      e0_r.cdist <= d_r[SQ2_STEPS].cdist;
      e0_r.nohit <= d_r[SQ2_STEPS].nohit;
      e0_r.coin  <= d_r[SQ2_STEPS].coin;

      e1_r <= e1_nxt;

      // The 59-bit magnitude times each axis is split in two partial products.
      for (int i = 0; i < 3; i++) begin
        e2_r.pl[i]   <= 63'(e1_r.fmag[29:0]) * 63'(e1_r.v.mag[i]);
        e2_r.ph[i]   <= 62'(e1_r.fmag[58:30]) * 62'(e1_r.v.mag[i]);
        e2_r.sign[i] <= e1_r.fneg ^ e1_r.v.neg[i];
      end
      e2_r.cdist <= e1_r.cdist;
      e2_r.nohit <= e1_r.nohit;
      e2_r.coin  <= e1_r.coin;

      for (int i = 0; i < 3; i++) begin
        e3_r.num[i] <= 92'(e2_r.pl[i]) + {e2_r.ph[i], 30'b0};
      end
      e3_r.sign  <= e2_r.sign;
      e3_r.cdist <= e2_r.cdist;
      e3_r.nohit <= e2_r.nohit;
      e3_r.coin  <= e2_r.coin;

      f_r[0] <= f0_nxt;
      for (int k = 1; k <= DIV2_STEPS; k++) begin
        f_r[k] <= f_step(f_r[k-1]);
      end

      out_data_r <= out_nxt;
    end
  end

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r) && out_valid)
    else $error("pipeline moved while the result beat was stalled");

  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coincident |->
      out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
    else $error("coincident beat carries a nonzero force");

  a_coin_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.coincident && out_data.saturated))
    else $error("coincident and saturated set together");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NSTG-1]))
    else $error("result beat appeared without an item in the last stage");

endmodule
`default_nettype wire
